// File: hdl/quadratic_least_squares_fit_core_defines.svh
// assertion macros for the quadratic least-squares fit core
`ifndef QUADRATIC_LEAST_SQUARES_FIT_CORE_DEFINES_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define QLSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define QLSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/qlsf_pkg.sv
// ----------------------------------------------------------------------------
// qlsf_pkg
// types, constants and arithmetic helpers for the quadratic fit core
// ----------------------------------------------------------------------------
`default_nettype none
package qlsf_pkg;
  localparam int InputBits   = 16;
  localparam int InFrac      = InputBits - 4;
  localparam int AccFrac     = 40;
  localparam int EpsBits     = 41;
  localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MaxNeg = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [InputBits-1:0] x_sample;
    logic signed [InputBits-1:0] y_sample;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] beta_const;
    logic signed [63:0] beta_linear;
    logic signed [63:0] beta_square;
    logic               fit_status;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) sat_add = a[63] ? MaxNeg : MaxPos;
    else sat_add = s;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) sat_sub = a[63] ? MaxNeg : MaxPos;
    else sat_sub = s;
  endfunction
endpackage
`default_nettype wire

// File: hdl/qlsf_arith.sv
// ----------------------------------------------------------------------------
// qlsf_arith
// shared multi-cycle multiply (32x32 partial products) and bit-serial divide
// ----------------------------------------------------------------------------
`default_nettype none
module qlsf_arith (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire qlsf_pkg::arith_ctl_t ctl,
  input  wire logic [63:0]          a,
  input  wire logic [63:0]          b,
  output logic                      done,
  output logic [63:0]               result
);
  import qlsf_pkg::*;

  logic [63:0]  ua, ub;
  logic         neg;
  logic         busy;
  arith_op_t    op;
  logic [6:0]   step;
  logic [127:0] prod;
  logic [63:0]  rem, nlo, quo;
  logic         ovf;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  rem_sh;
  logic         sub_ok;
  logic [127:0] sprod;
  logic [63:0]  rhi, rlo;

  // partial product select over four steps
  always_comb begin
    pa = step[0] ? ua[63:32] : ua[31:0];
    pb = step[1] ? ub[63:32] : ub[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << ({5'd0, step[0]} * 7'd32 + {5'd0, step[1]} * 7'd32);
    rem_sh = {rem, nlo[63]};
    sub_ok = rem_sh >= {1'b0, ub};
  end

  always_comb begin
    sprod = neg ? (~prod + 128'd1) : prod;
    rhi = 64'($signed(sprod) >>> (AccFrac + 64));
    rlo = sprod[AccFrac +: 64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        ua   <= mag64(a);
        ub   <= mag64(b);
        neg  <= a[63] ^ b[63];
        step <= '0;
        prod <= '0;
        rem  <= mag64(a) >> (64 - AccFrac);
        nlo  <= mag64(a) << AccFrac;
        quo  <= '0;
        ovf  <= (mag64(b) == 64'd0) || ((mag64(a) >> (64 - AccFrac)) >= mag64(b));
      end else if (busy) begin
        if (op == OP_MUL) begin
          if (step == 7'd4) begin
            busy <= 1'b0;
            done <= 1'b1;
            if (sprod[127] ? (rhi != '1 || !rlo[63]) : (rhi != '0 || rlo[63]))
              result <= sprod[127] ? MaxNeg : MaxPos;
            else result <= rlo;
          end else begin
            prod <= prod + pp_sh;
            step <= step + 7'd1;
          end
        end else begin
          if (step == 7'd64) begin
            busy <= 1'b0;
            done <= 1'b1;
            if (ovf) result <= neg ? MaxNeg : MaxPos;
            else if (neg) result <= quo[63] ? MaxNeg : (~quo + 64'd1);
            else result <= quo[63] ? MaxPos : quo;
          end else begin
            rem  <= sub_ok ? 64'(rem_sh - {1'b0, ub}) : rem_sh[63:0];
            quo  <= {quo[62:0], sub_ok};
            nlo  <= {nlo[62:0], 1'b0};
            step <= step + 7'd1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/quadratic_least_squares_fit_core.sv
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit_core
// quadratic least-squares fit of (x, y) samples by normal equations
// ----------------------------------------------------------------------------
// Samples (Q4.12) are accumulated into eight saturating Q24.40 moment sums;
// the last sample of a set starts a Gaussian elimination with partial pivoting
// and back substitution, and one item with the three coefficients and a status
// is produced. All products and quotients go through one shared unit: a
// multiply is built from four 32x32 partial products, a divide yields one
// quotient bit a cycle. Each sample takes five products. The input is stalled
// while an item is in work; the result sits in an output register until taken.
`default_nettype none
module quadratic_least_squares_fit_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire qlsf_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output qlsf_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [40:0]          cfg_data
);
  import qlsf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // waiting for a sample
    S_ACC   = 7'b0000010,  // sample products
    S_PIV   = 7'b0000100,  // pivot search and swap
    S_NORM  = 7'b0001000,  // divide pivot row
    S_ELIM  = 7'b0010000,  // eliminate lower rows
    S_BACK  = 7'b0100000,  // back substitution
    S_OUT   = 7'b1000000   // result waits
  } state_t;

  state_t      state;
  logic [40:0] eps;
  logic [63:0] sums [8];
  logic [63:0] aug [3][4];
  logic [63:0] xv, yv, x2, x3, x4, xy;
  logic [2:0]  mstep;
  logic        waiting;
  logic        is_last;
  logic [1:0]  p, r, c;
  logic [63:0] beta [3];
  logic [63:0] bacc;

  arith_ctl_t  actl;
  logic [63:0] aa, ab, ares;
  logic        adone;

  qlsf_arith u_arith (
    .clk(clk), .rst(rst), .ctl(actl), .a(aa), .b(ab), .done(adone), .result(ares)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !out_valid;

  // pivot search over the column, rows p..2
  logic [1:0]  best;
  logic [63:0] bv;
  always_comb begin
    best = p;
    bv = mag64(aug[p][p]);
    for (int i = 1; i < 3; i++) begin
      if (2'(i) > p && mag64(aug[i][p]) > bv) begin
        bv = mag64(aug[i][p]);
        best = 2'(i);
      end
    end
  end

  // operand select for the shared unit
  always_comb begin
    actl.start = 1'b0;
    actl.op = OP_MUL;
    aa = '0;
    ab = '0;
    case (state)
      S_ACC: begin
        case (mstep)
          3'd0: begin aa = xv; ab = xv; end
          3'd1: begin aa = x2; ab = xv; end
          3'd2: begin aa = x3; ab = xv; end
          3'd3: begin aa = xv; ab = yv; end
          default: begin aa = x2; ab = yv; end
        endcase
        actl.start = !waiting && mstep < 3'd5;
      end
      S_NORM: begin
        aa = aug[p][c]; ab = aug[p][p]; actl.op = OP_DIV;
        actl.start = !waiting;
      end
      S_ELIM: begin
        aa = aug[r][p]; ab = aug[p][c];
        actl.start = !waiting && mag64(aug[r][p]) >= {23'd0, eps};
      end
      S_BACK: begin
        aa = aug[r][c]; ab = beta[c];
        actl.start = !waiting && c != 2'd3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eps       <= 41'd1;
      out_valid <= 1'b0;
      waiting   <= 1'b0;
      for (int i = 0; i < 8; i++) sums[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) eps <= cfg_data;
      if (actl.start) waiting <= 1'b1;
      if (adone) waiting <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // sign-extend and align to Q24.40
            xv <= 64'(signed'(in_data.x_sample)) <<< (AccFrac - InFrac);
            yv <= 64'(signed'(in_data.y_sample)) <<< (AccFrac - InFrac);
            is_last <= in_data.last;
            mstep <= '0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (adone) begin
            case (mstep)
              3'd0: x2 <= ares;
              3'd1: x3 <= ares;
              3'd2: x4 <= ares;
              3'd3: xy <= ares;
              default: ;
            endcase
            mstep <= mstep + 3'd1;
            if (mstep == 3'd4) begin
              sums[0] <= sat_add(sums[0], 64'd1 << AccFrac);
              sums[1] <= sat_add(sums[1], xv);
              sums[2] <= sat_add(sums[2], x2);
              sums[3] <= sat_add(sums[3], x3);
              sums[4] <= sat_add(sums[4], x4);
              sums[5] <= sat_add(sums[5], yv);
              sums[6] <= sat_add(sums[6], xy);
              sums[7] <= sat_add(sums[7], ares);
              if (is_last) begin
                // build the normal equations from the updated sums
                aug[0][0] <= sat_add(sums[0], 64'd1 << AccFrac);
                aug[0][1] <= sat_add(sums[1], xv);
                aug[0][2] <= sat_add(sums[2], x2);
                aug[0][3] <= sat_add(sums[5], yv);
                aug[1][0] <= sat_add(sums[1], xv);
                aug[1][1] <= sat_add(sums[2], x2);
                aug[1][2] <= sat_add(sums[3], x3);
                aug[1][3] <= sat_add(sums[6], xy);
                aug[2][0] <= sat_add(sums[2], x2);
                aug[2][1] <= sat_add(sums[3], x3);
                aug[2][2] <= sat_add(sums[4], x4);
                aug[2][3] <= sat_add(sums[7], ares);
                p <= '0;
                state <= S_PIV;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_PIV: begin
          // empty-set test on count, then pivot magnitude test
          if ((p == 2'd0 && aug[0][0] == '0 && aug[1][0] == '0 && aug[2][0] == '0
               && sums[0] == '0) || bv < {23'd0, eps} || bv == '0) begin
            out_data  <= '{default: '0, fit_status: 1'b1};
            out_valid <= 1'b1;
            for (int i = 0; i < 8; i++) sums[i] <= '0;
            state <= S_OUT;
          end else begin
            if (best != p) begin
              for (int j = 0; j < 4; j++) begin
                if (2'(j) >= p) begin
                  aug[p][j] <= aug[best][j];
                  aug[best][j] <= aug[p][j];
                end
              end
            end
            c <= 2'd3;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // diagonal last so the divisor stays intact
          if (adone) begin
            aug[p][c] <= ares;
            if (c == p) begin
              r <= p + 2'd1;
              c <= p + 2'd1;
              state <= (p == 2'd2) ? S_BACK : S_ELIM;
              if (p == 2'd2) begin
                r <= 2'd2;
                c <= 2'd3;
                bacc <= aug[2][3];
              end
            end else begin
              c <= (c == 2'd3) ? p + 2'd1 : ((c == 2'd2) ? p : c + 2'd1);
              if (c == 2'd3 && p + 2'd1 > 2'd2) c <= p;
            end
          end
        end
        S_ELIM: begin
          if (!waiting && mag64(aug[r][p]) < {23'd0, eps}) begin
            // small factor: row left as is
            if (r == 2'd2) begin p <= p + 2'd1; state <= S_PIV; end
            else begin r <= r + 2'd1; c <= p + 2'd1; end
          end else if (adone) begin
            // factor column updated last
            aug[r][c] <= sat_sub(aug[r][c], ares);
            if (c == p) begin
              if (r == 2'd2) begin p <= p + 2'd1; state <= S_PIV; end
              else begin r <= r + 2'd1; c <= p + 2'd1; end
            end else if (c == 2'd3) c <= p;
            else c <= c + 2'd1;
          end
        end
        S_BACK: begin
          if (c == 2'd3) begin
            // row r complete
            beta[r] <= bacc;
            if (r == 2'd0) begin
              out_data <= '{beta_const: bacc, beta_linear: beta[1],
                            beta_square: beta[2], fit_status: 1'b0};
              out_valid <= 1'b1;
              for (int i = 0; i < 8; i++) sums[i] <= '0;
              state <= S_OUT;
            end else begin
              r <= r - 2'd1;
              c <= r;
              bacc <= aug[r - 2'd1][3];
            end
          end else if (adone) begin
            bacc <= sat_sub(bacc, ares);
            c <= (c == 2'd2) ? 2'd3 : c + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/qlsf_checker.sv
// ----------------------------------------------------------------------------
// qlsf_checker
// port-level checks of the quadratic fit core
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_least_squares_fit_core_defines.svh"
module qlsf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire qlsf_pkg::out_item_t out_data,
  input wire logic                cfg_ready
);
  import qlsf_pkg::*;

  `QLSF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result dropped")
  `QLSF_ASSERT_IMP(a_busy_out, out_valid, in_stall, "input taken while result waits")
  `QLSF_ASSERT_IMP(a_cfg_idle, cfg_ready, !out_valid && !in_stall, "config while busy")
  `QLSF_ASSERT_IMP(a_sing_zero, out_valid && out_data.fit_status, out_data.beta_const == '0 && out_data.beta_linear == '0 && out_data.beta_square == '0, "singular with betas")
  `QLSF_ASSERT_NXT(a_accept, in_valid && !in_stall, in_stall, "no work after accept")
endmodule

bind quadratic_least_squares_fit_core qlsf_checker u_qlsf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_ready(cfg_ready)
);
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the quadratic least-squares fit core
// ----------------------------------------------------------------------------
// A short table of directed samples runs first. It is followed by random sample
// sets under several pivot thresholds. A bit-accurate fixed-point solver in the
// bench predicts every fit item, and each item taken from the core is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qlsf_pkg::*;

  typedef logic signed [63:0] fix_t;

  localparam fix_t FixMax = 64'sh7fff_ffff_ffff_ffff;
  localparam fix_t FixMin = 64'sh8000_0000_0000_0000;
  localparam fix_t FixOne = 64'sh0000_0100_0000_0000;
  localparam int   IdleLimit = 20000;
  localparam int   TailCycles = 2000;
  localparam int   QuietItems = 60;

  // directed row; a fixed row expects a singular fit with zero coefficients
  typedef struct {
    in_item_t smp;
    bit       fixed;
  } smp_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [40:0] cfg_data = '0;

  // predictor state
  fix_t        moments[8];
  logic [63:0] eps_thr;
  out_item_t   fits_due[$];
  smp_row_t    rows[$];

  int  mismatches = 0;
  bit  quiet = 1'b0;
  int  idle_cnt = 0;
  int  rx_burst = 0;
  int  sent = 0;

  quadratic_least_squares_fit_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- fixed-point arithmetic of the solver ----------------

  function automatic logic [63:0] magn(fix_t v);
    return v[63] ? -v : v;
  endfunction

  // sum or difference clipped to the signed 64-bit range
  function automatic fix_t clip_sum(fix_t a, fix_t b, bit minus);
    logic signed [64:0] s;
    s = minus ? (a - b) : (a + b);
    if (s[64] != s[63]) return s[64] ? FixMin : FixMax;
    return s[63:0];
  endfunction

  // Q24.40 product, floored, clipped
  function automatic fix_t fix_prod(fix_t a, fix_t b);
    logic signed [127:0] p;
    p = a * b;
    p = p >>> 40;
    if (&p[127:63] || ~|p[127:63]) return p[63:0];
    return p[127] ? FixMin : FixMax;
  endfunction

  // Q24.40 quotient, truncated toward zero, clipped
  function automatic fix_t fix_quot(fix_t a, fix_t b);
    logic [63:0]  ua, ub;
    logic [127:0] num, q;
    bit neg;
    ua = magn(a);
    ub = magn(b);
    neg = a[63] != b[63];
    if (ub == 0 || (ua >> 24) >= ub) return neg ? FixMin : FixMax;
    num = 128'(ua) << 40;
    q = num / ub;
    if (neg) return (q >= 128'h8000_0000_0000_0000) ? FixMin : -fix_t'(q[63:0]);
    return (q > 128'h7fff_ffff_ffff_ffff) ? FixMax : fix_t'(q[63:0]);
  endfunction

  // normal equations, elimination with partial pivoting, back substitution
  function automatic out_item_t solve_fit();
    fix_t m[3][4];
    fix_t beta[3];
    fix_t diag, f, t, v;
    logic [63:0] best_mag;
    int best;
    out_item_t res;
    res = '0;
    res.fit_status = 1'b1;
    m[0] = '{moments[0], moments[1], moments[2], moments[5]};
    m[1] = '{moments[1], moments[2], moments[3], moments[6]};
    m[2] = '{moments[2], moments[3], moments[4], moments[7]};
    if (moments[0] == 0) return res;
    for (int p = 0; p < 3; p++) begin
      best = p;
      best_mag = magn(m[p][p]);
      for (int r = p + 1; r < 3; r++)
        if (magn(m[r][p]) > best_mag) begin
          best_mag = magn(m[r][p]);
          best = r;
        end
      if (best_mag < eps_thr || best_mag == 0) return res;
      if (best != p)
        for (int c = p; c < 4; c++) begin
          t = m[p][c];
          m[p][c] = m[best][c];
          m[best][c] = t;
        end
      diag = m[p][p];
      for (int c = p; c < 4; c++) m[p][c] = fix_quot(m[p][c], diag);
      for (int r = p + 1; r < 3; r++) begin
        f = m[r][p];
        // small factors leave the row alone
        if (magn(f) >= eps_thr)
          for (int c = p; c < 4; c++)
            m[r][c] = clip_sum(m[r][c], fix_prod(f, m[p][c]), 1'b1);
      end
    end
    for (int r = 2; r >= 0; r--) begin
      v = m[r][3];
      for (int c = r + 1; c < 3; c++) v = clip_sum(v, fix_prod(m[r][c], beta[c]), 1'b1);
      beta[r] = v;
    end
    res.beta_const  = beta[0];
    res.beta_linear = beta[1];
    res.beta_square = beta[2];
    res.fit_status  = 1'b0;
    return res;
  endfunction

  // accumulate one sample; returns 1 with the fit when the set ends
  function automatic bit add_sample(in_item_t s, output out_item_t fit);
    fix_t xv, yv, x2, x3, x4;
    fix_t terms[8];
    xv = s.x_sample;
    yv = s.y_sample;
    xv = xv <<< 28;
    yv = yv <<< 28;
    x2 = fix_prod(xv, xv);
    x3 = fix_prod(x2, xv);
    x4 = fix_prod(x3, xv);
    terms = '{FixOne, xv, x2, x3, x4, yv, fix_prod(xv, yv), fix_prod(x2, yv)};
    for (int i = 0; i < 8; i++) moments[i] = clip_sum(moments[i], terms[i], 1'b0);
    fit = '0;
    if (!s.last) return 1'b0;
    fit = solve_fit();
    foreach (moments[i]) moments[i] = '0;
    return 1'b1;
  endfunction

  // ---------------- sender side ----------------

  // hand one sample to the core, then predict; fixed rows expect singular
  task automatic push_sample(in_item_t s, bit fixed);
    int gap;
    out_item_t fit;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sent++;
    if (add_sample(s, fit)) begin
      if (fixed) begin
        fit = '0;
        fit.fit_status = 1'b1;
      end
      fits_due.push_back(fit);
    end
  endtask

  // threshold write only with the core idle and nothing outstanding
  task automatic set_threshold(logic [40:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (fits_due.size() == 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_thr = 64'(value);
  endtask

  // one random set: spread, narrow, or few distinct abscissas (rank loss)
  task automatic random_set(int total);
    int len, kind;
    logic [15:0] pick_a, pick_b;
    in_item_t s;
    len  = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
    kind = $urandom_range(0, 3);
    pick_a = 16'($urandom);
    pick_b = 16'($urandom);
    for (int k = 0; k < len; k++) begin
      case (kind)
        0: begin
          s.x_sample = 16'($urandom);
        end
        1: begin
          s.x_sample = 16'($urandom_range(0, 16383) - 8192);
        end
        2: begin
          s.x_sample = $urandom_range(0, 1) ? pick_a : pick_b;
        end
        default: begin
          s.x_sample = 16'($urandom_range(0, 511) - 256);
        end
      endcase
      s.y_sample = 16'($urandom);
      s.last = (k == len - 1);
      quiet = (sent >= total - QuietItems);
      push_sample(s, 1'b0);
    end
  endtask

  // ---------------- receiver side and checking ----------------

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (fits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected fit item %p", out_data);
      end else begin
        want = fits_due.pop_front();
        if (out_data.beta_const !== want.beta_const ||
            out_data.beta_linear !== want.beta_linear ||
            out_data.beta_square !== want.beta_square ||
            out_data.fit_status !== want.fit_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("fit mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
    // stall in bursts, never during the closing stretch
    if (rx_burst > 0) begin
      rx_burst <= rx_burst - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_burst  <= $urandom_range(1, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    logic [40:0] thresholds[5];
    int per_phase;
    thresholds = '{41'd1, 41'd0, 41'h100_0000_0000, 41'd0, 41'd1 << 20};
    thresholds[3] = {9'($urandom_range(0, 255)), $urandom};
    eps_thr = 64'd1;
    foreach (moments[i]) moments[i] = '0;

    // one sample at zero leaves the matrix rank one
    rows.push_back('{'{16'sd0, 16'sd0, 1'b1}, 1'b1});
    // field extremes
    rows.push_back('{'{16'sh7fff, 16'sh8000, 1'b0}, 1'b0});
    rows.push_back('{'{16'sh8000, 16'sh7fff, 1'b0}, 1'b0});
    rows.push_back('{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0});
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 1'b0}, 1'b0});
    rows.push_back('{'{16'sd1, 16'sd1, 1'b1}, 1'b0});
    // y = x^2 at -1, 0, 1
    rows.push_back('{'{-16'sd4096, 16'sd4096, 1'b0}, 1'b0});
    rows.push_back('{'{16'sd0, 16'sd0, 1'b0}, 1'b0});
    rows.push_back('{'{16'sd4096, 16'sd4096, 1'b1}, 1'b0});
    // one repeated abscissa: exactly singular
    rows.push_back('{'{16'sd4096, 16'sd100, 1'b0}, 1'b1});
    rows.push_back('{'{16'sd4096, -16'sd100, 1'b0}, 1'b1});
    rows.push_back('{'{16'sd4096, 16'sd7, 1'b1}, 1'b1});
    // two abscissas: last column pivot vanishes
    rows.push_back('{'{16'sd0, 16'sd5, 1'b0}, 1'b1});
    rows.push_back('{'{16'sd8192, 16'sd9, 1'b1}, 1'b1});
    // tiny spread, steep response
    rows.push_back('{'{16'sd1, 16'sh7fff, 1'b0}, 1'b0});
    rows.push_back('{'{16'sd2, 16'sh8000, 1'b0}, 1'b0});
    rows.push_back('{'{16'sd3, 16'sh7fff, 1'b1}, 1'b0});
    // wide spread with all-ones and all-zeros mixes
    rows.push_back('{'{16'shffff, 16'shffff, 1'b0}, 1'b0});
    rows.push_back('{'{16'sh5555, 16'shaaaa, 1'b0}, 1'b0});
    rows.push_back('{'{16'shaaaa, 16'sh5555, 1'b0}, 1'b0});
    rows.push_back('{'{16'sh8000, 16'sd0, 1'b1}, 1'b0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) push_sample(rows[i].smp, rows[i].fixed);

    // random sets under each threshold, zero and one among them
    per_phase = 750 / 5;
    foreach (thresholds[ph]) begin
      set_threshold(thresholds[ph]);
      while (sent < rows.size() + per_phase * (ph + 1))
        random_set(rows.size() + 750);
    end
    in_valid <= 1'b0;

    wait (fits_due.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && fits_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
